FILE: rtl/core/kea_pkg.sv
// kea_pkg: shared types, constants and the pixel blend function for the
// keystone edge antialias block; no dependencies
package kea_pkg;

  localparam int KEA_FRACTION_BITS = 18;
  localparam int KEA_DELTA_W       = 27;
  localparam int KEA_QUEUE_DEPTH   = 2;
  localparam logic [31:0] KEA_BG_PIXEL = 32'hff00_0000;

  typedef struct packed {
    logic        first_line;
    logic [31:0] left_edge_pixel;
    logic [31:0] left_inner_pixel;
    logic [31:0] right_inner_pixel;
    logic [31:0] right_edge_pixel;
  } kea_in_t;

  typedef struct packed {
    logic [31:0] left_out_zero;
    logic [31:0] left_out_one;
    logic [31:0] left_out_two;
    logic [31:0] right_out_zero;
    logic [31:0] right_out_one;
    logic [31:0] right_out_two;
    logic [31:0] right_out_three;
  } kea_out_t;

  // classified line, front to back
  typedef struct packed {
    logic [31:0] left_edge_pixel;
    logic [31:0] left_inner_pixel;
    logic [31:0] right_inner_pixel;
    logic [31:0] right_edge_pixel;
    logic [8:0]  keep_l;
    logic [8:0]  keep_r;
    logic        left_swap;
    logic        right_swap;
  } kea_job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } kea_q_stat_t;

  // scale colours by keep/256 and combine alpha with coverage
  function automatic logic [31:0] kea_blend(input logic [31:0] pix,
                                            input logic [8:0] keep);
    logic [7:0]  a;
    logic [8:0]  a_dec;
    logic [8:0]  inv_a;
    logic [17:0] prod_a;
    logic [16:0] a1;
    logic [8:0]  a1_hi;
    logic [7:0]  a_enc;
    logic [16:0] c0;
    logic [16:0] c1;
    logic [16:0] c2;
    a      = pix[31:24];
    a_dec  = {1'b0, a} + {8'd0, (a != 8'd0)};
    inv_a  = 9'd256 - a_dec;
    prod_a = inv_a * keep;
    a1     = 17'h1_0000 - prod_a[16:0];
    a1_hi  = a1[16:8];
    a_enc  = 8'(a1_hi - {8'd0, (a1_hi != 9'd0)});
    c0     = {9'd0, pix[7:0]}   * {8'd0, keep};
    c1     = {9'd0, pix[15:8]}  * {8'd0, keep};
    c2     = {9'd0, pix[23:16]} * {8'd0, keep};
    return {a_enc, c2[15:8], c1[15:8], c0[15:8]};
  endfunction

endpackage

FILE: rtl/core/kea_front.sv
// kea_front: accepts lines, keeps the edge position and works out coverage
// and column placement; uses kea_pkg
module kea_front #(
  parameter int FRACTION_BITS = kea_pkg::KEA_FRACTION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  kea_pkg::kea_in_t                       in_data,
  input  logic signed [kea_pkg::KEA_DELTA_W-1:0] edge_delta,
  input  kea_pkg::kea_q_stat_t                   q_stat,
  output logic                                   push,
  output kea_pkg::kea_job_t                      job
);

  logic [FRACTION_BITS-1:0] pos_r;
  logic [FRACTION_BITS-1:0] pos_nxt;
  logic [FRACTION_BITS-1:0] pos_cur;
  logic [FRACTION_BITS-1:0] pos_neg;
  logic [7:0]               beta_l;
  logic [7:0]               frac_r;
  logic                     delta_neg;

  assign in_stall  = q_stat.full;
  assign push      = in_valid && !q_stat.full;
  assign delta_neg = edge_delta[kea_pkg::KEA_DELTA_W-1];

  assign pos_cur = in_data.first_line ? '0 : pos_r;
  assign pos_neg = '0 - pos_cur;
  assign beta_l  = pos_neg[FRACTION_BITS-1 -: 8];
  assign frac_r  = pos_cur[FRACTION_BITS-1 -: 8];
  assign pos_nxt = pos_cur + edge_delta[FRACTION_BITS-1:0];

  always_comb begin
    job.left_edge_pixel   = in_data.left_edge_pixel;
    job.left_inner_pixel  = in_data.left_inner_pixel;
    job.right_inner_pixel = in_data.right_inner_pixel;
    job.right_edge_pixel  = in_data.right_edge_pixel;
    job.keep_l            = 9'd256 - {1'b0, beta_l};
    job.keep_r            = {1'b0, frac_r};
    // left edge moving right with no coverage: shift the blend inward
    job.left_swap         = delta_neg && (beta_l == 8'd0);
    // right edge moving left with minimal coverage: shift the blend inward
    job.right_swap        = delta_neg && (frac_r == 8'hff);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

FILE: rtl/core/kea_queue.sv
// kea_queue: short register queue between front and back
// uses kea_pkg
module kea_queue #(
  parameter int DEPTH = kea_pkg::KEA_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  kea_pkg::kea_job_t    push_job,
  input  logic                 pop,
  output kea_pkg::kea_job_t    pop_job,
  output kea_pkg::kea_q_stat_t stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  kea_pkg::kea_job_t slot_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r;
  logic [PW-1:0]     rd_ptr_nxt;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.valid = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/kea_back.sv
// kea_back: blends both edge pixels and places the seven output columns
// into the output register; uses kea_pkg
module kea_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  kea_pkg::kea_q_stat_t q_stat,
  input  kea_pkg::kea_job_t    job,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output kea_pkg::kea_out_t    out_data
);

  logic              out_valid_r;
  kea_pkg::kea_out_t out_data_r;
  kea_pkg::kea_out_t res;
  logic [31:0]       pl;
  logic [31:0]       pr;

  assign pop = q_stat.valid && (!out_valid_r || !out_stall);

  assign pl = kea_pkg::kea_blend(job.left_edge_pixel, job.keep_l);
  assign pr = kea_pkg::kea_blend(job.right_edge_pixel, job.keep_r);

  always_comb begin
    res.left_out_zero   = kea_pkg::KEA_BG_PIXEL;
    res.right_out_two   = kea_pkg::KEA_BG_PIXEL;
    res.right_out_three = kea_pkg::KEA_BG_PIXEL;
    if (job.left_swap) begin
      res.left_out_one = kea_pkg::KEA_BG_PIXEL;
      res.left_out_two = pl;
    end else begin
      res.left_out_one = pl;
      res.left_out_two = job.left_inner_pixel;
    end
    if (job.right_swap) begin
      res.right_out_zero = pr;
      res.right_out_one  = kea_pkg::KEA_BG_PIXEL;
    end else begin
      res.right_out_zero = job.right_inner_pixel;
      res.right_out_one  = pr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/keystone_edge_antialias_unit.sv
// keystone_edge_antialias_unit: top level of the keystone edge antialias block
// depends on kea_pkg, kea_front, kea_queue and kea_back
//
// channel | direction | handshake          | payload
// --------+-----------+--------------------+-------------------------------
// in_     | input     | in_valid/in_stall  | kea_in_t: first_line, 4 pixels
// out_    | output    | out_valid/out_stall| kea_out_t: 7 output columns
// cfg_    | input     | cfg_valid/cfg_ready| edge_delta, 27 bits signed
//
// one line per cycle sustained while out_stall is low; an accepted line is written
// into the queue and then popped into the output register, which raises out_valid
// the front's only state is the edge position, advanced by a single add per line
// rst_n is synchronous: clears edge position, edge_delta and all valids
// in_stall rises only when the queue is full, i.e. the output has been
// stalled long enough to back up; cfg_ready is always high
module keystone_edge_antialias_unit #(
  parameter int FRACTION_BITS = kea_pkg::KEA_FRACTION_BITS,
  parameter int QUEUE_DEPTH   = kea_pkg::KEA_QUEUE_DEPTH
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  kea_pkg::kea_in_t                       in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output kea_pkg::kea_out_t                      out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic signed [kea_pkg::KEA_DELTA_W-1:0] cfg_data
);

  // per-line right edge step; left edge uses its negation
  logic signed [kea_pkg::KEA_DELTA_W-1:0] edge_delta_r;

  kea_pkg::kea_job_t    push_job;
  kea_pkg::kea_job_t    pop_job;
  kea_pkg::kea_q_stat_t q_stat;
  logic                 push;
  logic                 pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_delta_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      edge_delta_r <= cfg_data;
    end
  end

  // front: edge position, coverage and swap decisions
  kea_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .edge_delta(edge_delta_r),
    .q_stat    (q_stat),
    .push      (push),
    .job       (push_job)
  );

  // decouples the front from output stalls
  kea_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .pop_job (pop_job),
    .stat    (q_stat)
  );

  // back: blend multipliers and output register
  kea_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .job      (pop_job),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // background columns are constant on every delivered item
  a_bg_cols : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.left_out_zero == kea_pkg::KEA_BG_PIXEL) &&
                  (out_data.right_out_two == kea_pkg::KEA_BG_PIXEL) &&
                  (out_data.right_out_three == kea_pkg::KEA_BG_PIXEL))
    else $error("background column corrupted");

  // an item accepted while the queue is empty always lands in the queue
  a_land : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !q_stat.valid) |=> q_stat.valid)
    else $error("accepted item lost before queue");

  // output drains when taken and nothing is queued
  a_drain : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !q_stat.valid) |=> !out_valid)
    else $error("output repeated without a queued item");

endmodule
